@@ design/efw_pkg.sv @@
package efw_pkg;

    localparam int TIME_W          = 48;
    localparam int DUR_W           = 31;
    localparam int WNUM_W          = 6;
    localparam int CFG_W           = 7;
    localparam int DEF_MAX_WORKERS = 64;
    localparam int RESET_WORKERS   = 64;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROOT,
        ST_RD_L,
        ST_RD_R,
        ST_CMP
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

@@ design/earliest_free_worker_scheduler_top.sv @@
// Channel   Handshake                 Payload
// request   i_start / o_busy          i_job_duration
// result    o_strobe                  o_worker_number, o_start_time
// config    i_cfg_we                  i_cfg_wdata
//
// A request reads the root and then sinks through the heap level by level until it comes to
// rest on a leaf or stops above one; each level does the two child reads from the memory
// read port and then the compare and write-back. The result strobe is registered from the
// root-read state and lasts one cycle. After reset and after each write of the worker
// count, a clearing pass fills the heap memory while o_busy stays high. The receiver
// cannot stall results.
module earliest_free_worker_scheduler_top #(
    parameter int MAX_WORKERS = efw_pkg::DEF_MAX_WORKERS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [efw_pkg::DUR_W-1:0]  i_job_duration,
    output logic                       o_busy,
    input  logic                       i_cfg_we,
    input  logic [efw_pkg::CFG_W-1:0]  i_cfg_wdata,
    output logic                       o_strobe,
    output logic [efw_pkg::WNUM_W-1:0] o_worker_number,
    output logic [efw_pkg::TIME_W-1:0] o_start_time
);
    import efw_pkg::*;

    localparam int AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int DW = TIME_W + AW;

    t_mem_ctl      mem_ctl;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_wdata;
    logic [DW-1:0] mem_rdata;

    efw_sift_ctrl #(
        .MAX_WORKERS (MAX_WORKERS),
        .AW          (AW),
        .DW          (DW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_job_duration  (i_job_duration),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_busy          (o_busy),
        .o_strobe        (o_strobe),
        .o_worker_number (o_worker_number),
        .o_start_time    (o_start_time),
        .o_mem_ctl       (mem_ctl),
        .o_waddr         (mem_waddr),
        .o_wdata         (mem_wdata),
        .o_raddr         (mem_raddr),
        .i_rdata         (mem_rdata)
    );

    efw_heap_ram #(
        .DEPTH (MAX_WORKERS),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

@@ design/efw_heap_ram.sv @@
module efw_heap_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 54
) (
    input  logic                i_clk,
    input  efw_pkg::t_mem_ctl   i_ctl,
    input  logic [AW-1:0]       i_waddr,
    input  logic [DW-1:0]       i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output logic [DW-1:0]       o_rdata
);
    import efw_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/efw_sift_ctrl.sv @@
module efw_sift_ctrl #(
    parameter int MAX_WORKERS = 64,
    parameter int AW          = 6,
    parameter int DW          = 54
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [efw_pkg::DUR_W-1:0]  i_job_duration,
    input  logic                       i_cfg_we,
    input  logic [efw_pkg::CFG_W-1:0]  i_cfg_wdata,
    output logic                       o_busy,
    output logic                       o_strobe,
    output logic [efw_pkg::WNUM_W-1:0] o_worker_number,
    output logic [efw_pkg::TIME_W-1:0] o_start_time,
    output efw_pkg::t_mem_ctl          o_mem_ctl,
    output logic [AW-1:0]              o_waddr,
    output logic [DW-1:0]              o_wdata,
    output logic [AW-1:0]              o_raddr,
    input  logic [DW-1:0]              i_rdata
);
    import efw_pkg::*;

    localparam int CW        = $clog2(MAX_WORKERS + 1);
    localparam int EW        = (CW > CFG_W) ? CW : CFG_W;
    localparam int LW        = AW + 2;
    localparam int IW        = (AW > WNUM_W) ? AW : WNUM_W;
    localparam int RST_COUNT = (MAX_WORKERS < RESET_WORKERS) ? MAX_WORKERS : RESET_WORKERS;

    t_state r_state, n_state;

    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_clr;
    logic [AW-1:0]     r_pos;
    logic [DUR_W-1:0]  r_dur;
    logic [DW-1:0]     r_cur;
    logic [DW-1:0]     r_left;
    logic              r_strobe;
    logic [WNUM_W-1:0] r_wnum;
    logic [TIME_W-1:0] r_start;

    logic [LW-1:0]     left_idx, right_idx;
    logic              left_ok, right_ok;
    logic              left_win, right_win;
    logic [DW-1:0]     best_lc;
    logic [TIME_W:0]   sum_wide;
    logic [TIME_W-1:0] sum_sat;
    logic [EW-1:0]     cfg_ext;
    logic [IW-1:0]     root_id;

    assign left_idx  = LW'({r_pos, 1'b1});
    assign right_idx = LW'({r_pos, 1'b0}) + LW'(2);
    assign left_ok   = left_idx < LW'(r_count);
    assign right_ok  = right_idx < LW'(r_count);
    assign left_win  = r_left < r_cur;
    assign best_lc   = left_win ? r_left : r_cur;
    assign right_win = right_ok && (i_rdata < best_lc);

    assign sum_wide = {1'b0, i_rdata[DW-1:AW]} + (TIME_W + 1)'(r_dur);
    assign sum_sat  = sum_wide[TIME_W] ? {TIME_W{1'b1}} : sum_wide[TIME_W-1:0];
    assign root_id  = IW'(i_rdata[AW-1:0]);

    assign cfg_ext = EW'(i_cfg_wdata);
    always_comb begin
        if (cfg_ext == '0) begin
            n_count = CW'(1);
        end else if (cfg_ext > EW'(MAX_WORKERS)) begin
            n_count = CW'(MAX_WORKERS);
        end else begin
            n_count = CW'(cfg_ext);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(MAX_WORKERS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: n_state = ST_RD_L;
            ST_RD_L: n_state = left_ok ? ST_RD_R : ST_IDLE;
            ST_RD_R: n_state = ST_CMP;
            ST_CMP:  n_state = (left_win || right_win) ? ST_RD_L : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        if (i_cfg_we) begin
            n_state = ST_CLEAR;
        end
    end

    always_comb begin
        o_mem_ctl = '0;
        o_waddr   = r_pos;
        o_wdata   = r_cur;
        o_raddr   = '0;
        o_busy    = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_mem_ctl.wr_en = 1'b1;
                o_waddr         = r_clr;
                o_wdata         = {{TIME_W{1'b0}}, r_clr};
            end
            ST_IDLE: begin
                o_busy          = 1'b0;
                o_mem_ctl.rd_en = i_start;
            end
            ST_ROOT: begin
            end
            ST_RD_L: begin
                o_mem_ctl.rd_en = left_ok;
                o_mem_ctl.wr_en = !left_ok;
                o_raddr         = left_idx[AW-1:0];
            end
            ST_RD_R: begin
                o_mem_ctl.rd_en = right_ok;
                o_raddr         = right_idx[AW-1:0];
            end
            ST_CMP: begin
                o_mem_ctl.wr_en = 1'b1;
                if (right_win) begin
                    o_wdata = i_rdata;
                end else if (left_win) begin
                    o_wdata = r_left;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_count  <= CW'(RST_COUNT);
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_ROOT);
            if (i_cfg_we) begin
                r_count <= n_count;
                r_clr   <= '0;
            end else if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_dur <= i_job_duration;
        end
        if (r_state == ST_ROOT) begin
            r_wnum  <= root_id[WNUM_W-1:0];
            r_start <= i_rdata[DW-1:AW];
            r_cur   <= {sum_sat, i_rdata[AW-1:0]};
            r_pos   <= '0;
        end
        if (r_state == ST_RD_R) begin
            r_left <= i_rdata;
        end
        if (r_state == ST_CMP) begin
            if (right_win) begin
                r_pos <= right_idx[AW-1:0];
            end else if (left_win) begin
                r_pos <= left_idx[AW-1:0];
            end
        end
    end

    assign o_strobe        = r_strobe;
    assign o_worker_number = r_wnum;
    assign o_start_time    = r_start;

endmodule

@@ tb/sv/tb_top.sv @@
typedef struct {
    logic [efw_pkg::WNUM_W-1:0] worker;
    logic [efw_pkg::TIME_W-1:0] start;
} t_assignment;

class dispatch_scoreboard;
    localparam int NW = efw_pkg::DEF_MAX_WORKERS;

    logic [efw_pkg::TIME_W-1:0] free_time [NW];
    int unsigned                worker_id [NW];
    int unsigned                active;
    t_assignment                pending_assignments [$];
    int unsigned                errors;
    int unsigned                checked;

    function new();
        errors  = 0;
        checked = 0;
        set_worker_count(efw_pkg::CFG_W'(efw_pkg::RESET_WORKERS));
    endfunction

    function void set_worker_count(logic [efw_pkg::CFG_W-1:0] value);
        if (value == 0) begin
            active = 1;
        end else if (value > NW) begin
            active = NW;
        end else begin
            active = value;
        end
        for (int i = 0; i < NW; i++) begin
            free_time[i] = '0;
            worker_id[i] = i;
        end
    endfunction

    function bit ahead(int unsigned a, int unsigned b);
        if (free_time[a] != free_time[b]) begin
            return free_time[a] < free_time[b];
        end
        return worker_id[a] < worker_id[b];
    endfunction

    function void note_job(logic [efw_pkg::DUR_W-1:0] duration);
        t_assignment                exp_item;
        logic [efw_pkg::TIME_W:0]   sum;
        logic [efw_pkg::TIME_W-1:0] t;
        int unsigned                pos;
        int unsigned                best;
        int unsigned                w;
        exp_item.worker = worker_id[0][efw_pkg::WNUM_W-1:0];
        exp_item.start  = free_time[0];
        pending_assignments.push_back(exp_item);
        sum = {1'b0, free_time[0]} + duration;
        free_time[0] = sum[efw_pkg::TIME_W] ? '1 : sum[efw_pkg::TIME_W-1:0];
        pos = 0;
        forever begin
            best = pos;
            if (2 * pos + 1 < active && ahead(2 * pos + 1, best)) begin
                best = 2 * pos + 1;
            end
            if (2 * pos + 2 < active && ahead(2 * pos + 2, best)) begin
                best = 2 * pos + 2;
            end
            if (best == pos) begin
                break;
            end
            t               = free_time[pos];
            free_time[pos]  = free_time[best];
            free_time[best] = t;
            w               = worker_id[pos];
            worker_id[pos]  = worker_id[best];
            worker_id[best] = w;
            pos = best;
        end
    endfunction

    function void check_result(logic [efw_pkg::WNUM_W-1:0] worker,
                               logic [efw_pkg::TIME_W-1:0] start);
        t_assignment exp_item;
        if (pending_assignments.size() == 0) begin
            $error("unexpected result: worker_number %0d, start_time %0d", worker, start);
            errors++;
            return;
        end
        exp_item = pending_assignments.pop_front();
        checked++;
        if (worker !== exp_item.worker) begin
            $error("worker_number mismatch: expected %0d, actual %0d",
                   exp_item.worker, worker);
            errors++;
        end
        if (start !== exp_item.start) begin
            $error("start_time mismatch: expected %0d, actual %0d", exp_item.start, start);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import efw_pkg::*;

    localparam logic [DUR_W-1:0] MAX_DUR     = '1;
    localparam int               SETTLE      = 30;
    localparam longint           CYCLE_LIMIT = 400000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic [DUR_W-1:0]     i_job_duration;
    logic                 o_busy;
    logic                 i_cfg_we;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 o_strobe;
    logic [WNUM_W-1:0]    o_worker_number;
    logic [TIME_W-1:0]    o_start_time;

    dispatch_scoreboard   sb;
    longint               cycles;
    int unsigned          jobs_sent;
    int unsigned          settings_used;

    earliest_free_worker_scheduler_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_job_duration  (i_job_duration),
        .o_busy          (o_busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_strobe        (o_strobe),
        .o_worker_number (o_worker_number),
        .o_start_time    (o_start_time)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                sb.check_result(o_worker_number, o_start_time);
            end
            if (i_start && !o_busy) begin
                sb.note_job(i_job_duration);
            end
        end
    end

    // Leaves i_start high after acceptance; the caller either sends again or lowers it.
    task automatic send_job(input logic [DUR_W-1:0] duration);
        i_start        <= 1'b1;
        i_job_duration <= duration;
        do begin
            @(posedge i_clk);
        end while (o_busy);
        jobs_sent++;
    endtask

    task automatic idle_cycles(input int unsigned n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.pending_assignments.size() != 0);
    endtask

    task automatic write_worker_count(input logic [CFG_W-1:0] value);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_worker_count(value);
        settings_used++;
        i_cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
    endtask

    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(4, 0))
            0: return '0;
            1: return DUR_W'($urandom_range(15, 0));
            2: return DUR_W'($urandom_range(1000, 0));
            3: return DUR_W'($urandom_range(MAX_DUR - 16, MAX_DUR));
            default: return DUR_W'($urandom());
        endcase
    endfunction

    task automatic run_random(input int unsigned n);
        int unsigned left;
        int unsigned burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(24, 1);
            while (burst > 0 && left > 0) begin
                send_job(pick_duration());
                burst--;
                left--;
            end
            if ($urandom_range(15, 0) == 0) begin
                drain();
            end else if ($urandom_range(3, 0) != 0) begin
                idle_cycles($urandom_range(12, 1));
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] phase_counts [10];
        sb             = new();
        cycles         = 0;
        jobs_sent      = 0;
        settings_used  = 0;
        i_rst_n        <= 1'b0;
        i_start        <= 1'b0;
        i_job_duration <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default count of 64: ties on zero free time resolve by worker number.
        send_job(0);
        send_job(0);
        send_job(0);
        send_job(MAX_DUR);
        send_job(1);
        send_job(MAX_DUR);
        send_job(5);
        idle_cycles(3);
        send_job(0);
        send_job(2);
        send_job(MAX_DUR);

        // A count of zero acts as one worker; counts above the maximum saturate.
        write_worker_count(0);
        send_job(MAX_DUR);
        send_job(7);
        send_job(0);
        write_worker_count(127);
        send_job(3);
        send_job(MAX_DUR);
        send_job(0);
        write_worker_count(65);
        send_job(1);
        send_job(1);
        write_worker_count(1);
        send_job(MAX_DUR);
        send_job(0);
        send_job(MAX_DUR);

        phase_counts = '{7'd64, 7'd1, 7'd2, 7'd3, 7'd7, 7'd33, 7'd100, 7'd16, 7'd64, 7'd5};
        phase_counts[9] = CFG_W'($urandom_range(127, 0));
        foreach (phase_counts[p]) begin
            write_worker_count(phase_counts[p]);
            run_random(110);
        end

        write_worker_count(2);
        run_random(20);

        drain();
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d jobs across %0d worker-count settings, checked %0d results.",
                 jobs_sent, settings_used, sb.checked);
        $display("Covered ties, count clamping, long jobs, bursty and back-to-back requests.");
        if (sb.errors == 0 && sb.pending_assignments.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

@@ files.f @@
design/efw_pkg.sv
design/efw_heap_ram.sv
design/efw_sift_ctrl.sv
design/earliest_free_worker_scheduler_top.sv
tb/sv/tb_top.sv
